FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: design/tsremap_pkg.sv
// Shared types, constants and fake PSI tables for the transport stream PID remapper.
`default_nettype none
package tsremap_pkg;

	localparam int unsigned PACKET_WORDS = 47;
	localparam int unsigned POS_W        = 6;
	localparam int unsigned PID_W        = 13;
	localparam int unsigned REG_W        = 14;
	localparam int unsigned IDX_W        = 3;

	localparam logic [7:0]       SYNC_BYTE   = 8'h47;
	localparam logic [PID_W-1:0] PID_PAT     = 13'h0000;
	localparam logic [PID_W-1:0] PID_OUT_PCR = 13'h0021;
	localparam logic [PID_W-1:0] PID_OUT_VID = 13'h0030;
	localparam logic [PID_W-1:0] PID_OUT_AUD = 13'h0031;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE    = 3'd0,
		REG_PMT_PID   = 3'd1,
		REG_PCR_PID   = 3'd2,
		REG_AUDIO_PID = 3'd3,
		REG_VIDEO_PID = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_DROP = 2'd0,
		ACT_PAT  = 2'd1,
		ACT_PMT  = 2'd2,
		ACT_PASS = 2'd3
	} action_t;

	// Fake PAT: one program 0x456 on PMT PID 0x20.
	localparam logic [31:0] PAT_W0 = 32'h47400010;
	localparam logic [31:0] PAT_W1 = 32'h0000800D;
	localparam logic [31:0] PAT_W2 = 32'h00040100;
	localparam logic [31:0] PAT_W3 = 32'h00045600;
	localparam logic [31:0] PAT_W4 = 32'h20000000;

	// Fake PMT on PID 0x20: video 0x30, audio 0x31, PCR PID in word 3.
	localparam logic [31:0] PMT_W0 = 32'h47402010;
	localparam logic [31:0] PMT_W1 = 32'h00028016;
	localparam logic [31:0] PMT_W2 = 32'h00040100;
	localparam logic [31:0] PMT_W4 = 32'h00020030;
	localparam logic [31:0] PMT_W5 = 32'h00000300;
	localparam logic [31:0] PMT_W6 = 32'h31000000;

	function automatic logic [31:0] fake_word(input action_t act, input logic [POS_W-1:0] idx,
			input logic pcr_is_video);
		logic [31:0] w;
		w = '0;
		if (act == ACT_PAT) begin
			case (idx)
				6'd0: w = PAT_W0;
				6'd1: w = PAT_W1;
				6'd2: w = PAT_W2;
				6'd3: w = PAT_W3;
				6'd4: w = PAT_W4;
				default: w = '0;
			endcase
		end else begin
			case (idx)
				6'd0: w = PMT_W0;
				6'd1: w = PMT_W1;
				6'd2: w = PMT_W2;
				6'd3: w = {11'd0, pcr_is_video ? PID_OUT_VID : PID_OUT_PCR, 8'd0};
				6'd4: w = PMT_W4;
				6'd5: w = PMT_W5;
				6'd6: w = PMT_W6;
				default: w = '0;
			endcase
		end
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: design/ts_pid_remap_psi_replace.sv
// Transport stream PID remapper that swaps PAT/PMT for fixed fake tables.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-----------------------
//  in      | packet_word[31:0], start_of_packet               | in_valid / in_ready
//  out     | out_word[31:0], end_of_packet                    | out_valid / out_ready
//  config  | reg_index[2:0], write_data[13:0]                 | write_enable, no wait
//
// One word per cycle while no held result waits on out_ready; a result shows in the cycle after its request is taken.
// The word is decided by a short compare and select path into the output register.
// in_ready is low only while a held result waits on out_ready.
// Dropped words leave no result; reset clears the control state (not the output word) and the registers
// (enable off, every PID unset).
`default_nettype none
module ts_pid_remap_psi_replace
	import tsremap_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             write_enable,
	input  wire logic [IDX_W-1:0] reg_index,
	input  wire logic [REG_W-1:0] write_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [31:0]      packet_word,
	input  wire logic             start_of_packet,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [31:0]           out_word,
	output logic                  end_of_packet
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_WORDS - 1);
	localparam logic [POS_W-1:0] END_POS  = POS_W'(PACKET_WORDS);

	logic             enable_q;
	logic [REG_W-1:0] pmt_pid_q, pcr_pid_q, audio_pid_q, video_pid_q;
	logic [POS_W-1:0] pos_q;
	action_t          act_q;
	logic             out_valid_q;
	logic [31:0]      out_word_q;
	logic             eop_q;

	logic             accept;
	logic [PID_W-1:0] pid;
	logic             pusi;
	logic             cfg_ok;
	logic             pcr_is_video;
	logic             hit_pmt, hit_pcr, hit_video, hit_audio;
	action_t          new_act;
	logic [PID_W-1:0] new_pid;
	logic             res_valid;
	logic [31:0]      res_word;
	logic             res_eop;

	assign in_ready      = !out_valid_q || out_ready;
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign out_word      = out_word_q;
	assign end_of_packet = eop_q;

	assign pid          = packet_word[20:8];
	assign pusi         = packet_word[22];
	assign cfg_ok       = enable_q && !pcr_pid_q[REG_W-1] && !audio_pid_q[REG_W-1]
		&& !pmt_pid_q[REG_W-1];
	assign pcr_is_video = (pcr_pid_q == video_pid_q);
	assign hit_pmt      = !pmt_pid_q[REG_W-1] && (pmt_pid_q[PID_W-1:0] == pid);
	assign hit_pcr      = !pcr_pid_q[REG_W-1] && (pcr_pid_q[PID_W-1:0] == pid);
	assign hit_video    = !video_pid_q[REG_W-1] && (video_pid_q[PID_W-1:0] == pid);
	assign hit_audio    = !audio_pid_q[REG_W-1] && (audio_pid_q[PID_W-1:0] == pid);

	// classify the packet from its header word
	always_comb begin
		new_act = ACT_DROP;
		new_pid = PID_OUT_AUD;
		if (cfg_ok) begin
			if (pid == PID_PAT) begin
				new_act = pusi ? ACT_PAT : ACT_DROP;
			end else if (hit_pmt) begin
				new_act = pusi ? ACT_PMT : ACT_DROP;
			end else if (hit_pcr) begin
				new_act = ACT_PASS;
				new_pid = pcr_is_video ? PID_OUT_VID : PID_OUT_PCR;
			end else if (hit_video) begin
				new_act = ACT_PASS;
				new_pid = PID_OUT_VID;
			end else if (hit_audio) begin
				new_act = ACT_PASS;
				new_pid = PID_OUT_AUD;
			end
		end
	end

	always_comb begin
		res_eop = 1'b0;
		if (start_of_packet) begin
			res_valid = (new_act != ACT_DROP);
			if (new_act == ACT_PASS) begin
				// clear error and priority bits, keep PUSI
				res_word = {packet_word[31:24], 1'b0, pusi, 1'b0, new_pid, packet_word[7:0]};
			end else begin
				res_word = fake_word(new_act, '0, pcr_is_video);
			end
		end else begin
			res_valid = (act_q != ACT_DROP) && (pos_q < END_POS);
			res_word  = (act_q == ACT_PASS) ? packet_word : fake_word(act_q, pos_q, pcr_is_video);
			res_eop   = (pos_q == LAST_POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			pmt_pid_q   <= '1;
			pcr_pid_q   <= '1;
			audio_pid_q <= '1;
			video_pid_q <= '1;
		end else if (write_enable) begin
			case (reg_index)
				REG_ENABLE:    enable_q    <= write_data[0];
				REG_PMT_PID:   pmt_pid_q   <= write_data;
				REG_PCR_PID:   pcr_pid_q   <= write_data;
				REG_AUDIO_PID: audio_pid_q <= write_data;
				REG_VIDEO_PID: video_pid_q <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			act_q       <= ACT_DROP;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
			if (start_of_packet) begin
				act_q <= new_act;
				pos_q <= POS_W'(1);
			end else begin
				// saturate once past the last word
				if (pos_q < END_POS) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (res_valid && res_eop) begin
					act_q <= ACT_DROP;
				end
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q <= res_word;
			eop_q      <= res_eop;
		end
	end

endmodule
`default_nettype wire

FILE: design/tsremap_checker.sv
// Port-level checker for the transport stream PID remapper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tsremap_checker
	import tsremap_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [31:0] packet_word,
	input wire logic        start_of_packet,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_word,
	input wire logic        end_of_packet
);

	logic in_take;
	logic pat_no_pusi;

	assign in_take     = in_valid && in_ready;
	assign pat_no_pusi = start_of_packet && (packet_word[20:8] == PID_PAT) && !packet_word[22];

	// an empty output register never blocks a request
	`ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
	// a result only appears after a taken request
	`ASSERT_NOW(a_result_has_request, $rose(out_valid), $past(in_take))
	// PAT without payload-unit-start is dropped
	`ASSERT_NEXT(a_pat_cont_dropped, in_take && pat_no_pusi, !out_valid)
	// the first word of a packet never closes it
	`ASSERT_NEXT(a_first_not_last, in_take && start_of_packet, !(out_valid && end_of_packet))
	// hold a stalled result
	`ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(out_word) && $stable(end_of_packet))

endmodule

bind ts_pid_remap_psi_replace tsremap_checker u_tsremap_checker (.*);
`default_nettype wire
